### src/lpfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed frame parser.
// No dependencies; every other file of the block imports this package.
package lpfp_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam int QUEUE_DEPTH  = 4;
  localparam int CFG_IDX_W    = 2;

  localparam logic [31:0] MAX_TYPE_RESET   = 32'd1000;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'd8000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD    = 2'd1;
  localparam logic [1:0] KIND_BAD_HEADER = 2'd2;
  localparam logic [1:0] KIND_MID_CLOSE  = 2'd3;

  // Input actions.
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [7:0]         data_byte;
    logic signed [63:0] stamp;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        msg_type;
    logic [31:0]        msg_length;
    logic [7:0]         payload_byte;
    logic               last;
    logic signed [63:0] out_stamp;
  } result_t;

endpackage

### src/lpfp_front.sv
`timescale 1ns / 1ps
// Front end: accepts stream words, gathers headers, checks limits and
// produces at most one result per word. Depends on lpfp_pkg.
module lpfp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  lpfp_pkg::item_t                 item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            q_full,
  output logic                            res_valid,
  output lpfp_pkg::result_t               res
);
  import lpfp_pkg::*;

  logic [31:0]          max_type;
  logic [31:0]          max_length;
  logic [63:0]          hdr_shift;
  logic [63:0]          hdr_shift_next;
  logic [HDR_IDX_W-1:0] hdr_count;
  logic [HDR_IDX_W-1:0] hdr_count_next;
  logic                 in_payload;
  logic                 in_payload_next;
  logic [31:0]          bytes_left;
  logic [31:0]          bytes_left_next;
  logic                 cancelled;
  logic                 cancelled_next;
  logic                 accept;
  logic [31:0]          cur_type;
  logic [31:0]          cur_len;
  logic [31:0]          new_type;
  logic [31:0]          new_len;
  logic [31:0]          left_dec;

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign cfg_ready = 1'b1;
  assign cur_type  = hdr_shift[31:0];
  assign cur_len   = hdr_shift[63:32];
  assign new_type  = hdr_shift_next[31:0];
  assign new_len   = hdr_shift_next[63:32];
  assign left_dec  = (bytes_left != 32'd0) ? bytes_left - 32'd1 : 32'd0;

  // Byte lane i takes the new byte when the count points at it; a fresh
  // header (count zero) clears the lanes left over from the last frame.
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (hdr_count == i[HDR_IDX_W-1:0]) begin
        hdr_shift_next[8*i +: 8] = item.data_byte;
      end else if (hdr_count == '0) begin
        hdr_shift_next[8*i +: 8] = 8'd0;
      end else begin
        hdr_shift_next[8*i +: 8] = hdr_shift[8*i +: 8];
      end
    end
  end

  always_comb begin
    res_valid        = 1'b0;
    res.kind         = KIND_HEADER;
    res.msg_type     = cur_type;
    res.msg_length   = cur_len;
    res.payload_byte = 8'd0;
    res.last         = 1'b1;
    res.out_stamp    = item.stamp;
    hdr_count_next   = hdr_count;
    in_payload_next  = in_payload;
    bytes_left_next  = bytes_left;
    cancelled_next   = cancelled;
    if (item.action == ACT_CLOSE) begin
      if (!cancelled && (in_payload || hdr_count != '0)) begin
        res_valid = 1'b1;
        res.kind  = KIND_MID_CLOSE;
        if (!in_payload) begin
          res.msg_type   = 32'd0;
          res.msg_length = 32'd0;
        end
      end
      hdr_count_next  = '0;
      in_payload_next = 1'b0;
      bytes_left_next = 32'd0;
      cancelled_next  = 1'b0;
    end else if (cancelled) begin
      res_valid = 1'b0;
    end else if (in_payload) begin
      res_valid        = 1'b1;
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = item.data_byte;
      res.last         = (left_dec == 32'd0);
      bytes_left_next  = left_dec;
      in_payload_next  = (left_dec != 32'd0);
    end else if (hdr_count == HDR_IDX_W'(HEADER_BYTES - 1)) begin
      res_valid      = 1'b1;
      res.msg_type   = new_type;
      res.msg_length = new_len;
      hdr_count_next = '0;
      if (new_type > max_type || new_len > max_length) begin
        res.kind       = KIND_BAD_HEADER;
        cancelled_next = 1'b1;
      end else begin
        res.last        = (new_len == 32'd0);
        in_payload_next = (new_len != 32'd0);
        bytes_left_next = new_len;
      end
    end else begin
      hdr_count_next = hdr_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_type   <= MAX_TYPE_RESET;
      max_length <= MAX_LENGTH_RESET;
      hdr_shift  <= 64'd0;
      hdr_count  <= '0;
      in_payload <= 1'b0;
      bytes_left <= 32'd0;
      cancelled  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_TYPE:   max_type   <= cfg_data;
          REG_MAX_LENGTH: max_length <= cfg_data;
          default:        ;
        endcase
      end
      if (accept) begin
        if (item.action == ACT_BYTE && !cancelled && !in_payload) begin
          hdr_shift <= hdr_shift_next;
        end
        hdr_count  <= hdr_count_next;
        in_payload <= in_payload_next;
        bytes_left <= bytes_left_next;
        cancelled  <= cancelled_next;
      end
    end
  end

endmodule

### src/lpfp_queue.sv
`timescale 1ns / 1ps
// Short result queue between the front end and the output stage.
// Depends on lpfp_pkg for the result type.
module lpfp_queue #(
  parameter int DEPTH = lpfp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  lpfp_pkg::result_t wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output logic              q_valid,
  output lpfp_pkg::result_t rd_data
);
  import lpfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/lpfp_back.sv
`timescale 1ns / 1ps
// Output stage: holds the oldest result word on the ports until popped
// and refills from the result queue. Depends on lpfp_pkg.
module lpfp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lpfp_pkg::result_t q_data,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output lpfp_pkg::result_t result
);
  import lpfp_pkg::*;

  logic    out_valid;
  result_t out_reg;

  // Refill whenever the register is free or is being emptied this cycle.
  assign q_rd   = q_valid && (!out_valid || pop);
  assign empty  = !out_valid;
  assign result = out_reg;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      out_reg <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### src/length_prefixed_frame_parser_core.sv
`timescale 1ns / 1ps
// Length-prefixed frame parser. One stream word is taken per cycle while
// the result queue has room; its result is queued at the accepting edge
// and is loaded into the output register once that register is free or
// being popped. The front end computes each word's result combinationally,
// so only a full queue holds the input. Synchronous reset clears parse state,
// queue and output; limits return to their defaults.
module length_prefixed_frame_parser_core #(
  parameter int QUEUE_DEPTH = lpfp_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  lpfp_pkg::item_t                item,
  output logic                           empty,
  input  logic                           pop,
  output lpfp_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import lpfp_pkg::*;

  logic    q_full;
  logic    res_valid;
  result_t res;
  logic    q_valid;
  logic    q_rd;
  result_t q_data;

  lpfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid && push && !full),
    .wr_data (res),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .q_valid (q_valid),
    .rd_data (q_data)
  );

  lpfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

### src/lpfp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the frame parser, bound to the top level.
// Depends on lpfp_pkg and length_prefixed_frame_parser_core.
module lpfp_port_checks (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input lpfp_pkg::result_t result
);
  import lpfp_pkg::*;

  // Cancels always close the frame.
  a_cancel_last: assert property (@(posedge clk) disable iff (rst)
    !empty && (result.kind == KIND_BAD_HEADER || result.kind == KIND_MID_CLOSE)
      |-> result.last)
    else $error("cancel word without last");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind != KIND_PAYLOAD |-> result.payload_byte == 8'd0)
    else $error("payload byte set on a non-payload word");

  // A header word is last exactly when its frame has no payload.
  a_hdr_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == KIND_HEADER |-> result.last == (result.msg_length == 32'd0))
    else $error("header last flag disagrees with length");

  a_reset: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

endmodule

bind length_prefixed_frame_parser_core lpfp_port_checks u_lpfp_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

### tb/lpfp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the length-prefixed frame parser: watches every channel,
// keeps its own parser state and compares results. Depends on lpfp_pkg.
module lpfp_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  lpfp_pkg::item_t                item,
  input  logic                           empty,
  input  logic                           pop,
  input  lpfp_pkg::result_t              result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lpfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int unsigned                    outstanding
);
  import lpfp_pkg::*;

  logic [31:0] lim_type;
  logic [31:0] lim_len;
  logic [63:0] hdr_bits;
  int          hdr_cnt;
  logic        in_body;
  logic [31:0] body_left;
  logic        dropping;
  result_t     frame_events[$];
  result_t     want;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
    end
  endtask

  task automatic clear_parse();
    hdr_bits  = '0;
    hdr_cnt   = 0;
    in_body   = 1'b0;
    body_left = '0;
    dropping  = 1'b0;
  endtask

  // Advances the parser by one accepted word and queues the result it causes.
  task automatic parse_word(input item_t w);
    logic [31:0] cur_type;
    logic [31:0] cur_len;
    result_t     r;
    cur_type    = hdr_bits[31:0];
    cur_len     = hdr_bits[63:32];
    r           = '0;
    r.out_stamp = w.stamp;
    r.last      = 1'b1;
    if (w.action == ACT_CLOSE) begin
      // A close reports a cut frame only if something was started and the
      // stream was not already cancelled.
      if (!dropping && (in_body || hdr_cnt != 0)) begin
        r.kind = KIND_MID_CLOSE;
        if (in_body) begin
          r.msg_type   = cur_type;
          r.msg_length = cur_len;
        end
        frame_events.push_back(r);
      end
      clear_parse();
    end else if (!dropping) begin
      if (in_body) begin
        if (body_left != 0) body_left--;
        if (body_left == 0) in_body = 1'b0;
        r.kind         = KIND_PAYLOAD;
        r.msg_type     = cur_type;
        r.msg_length   = cur_len;
        r.payload_byte = w.data_byte;
        r.last         = (body_left == 0);
        frame_events.push_back(r);
      end else begin
        if (hdr_cnt == 0) hdr_bits = '0;
        hdr_bits[hdr_cnt*8 +: 8] = w.data_byte;
        hdr_cnt++;
        if (hdr_cnt == HEADER_BYTES) begin
          hdr_cnt      = 0;
          r.msg_type   = hdr_bits[31:0];
          r.msg_length = hdr_bits[63:32];
          if (r.msg_type > lim_type || r.msg_length > lim_len) begin
            dropping = 1'b1;
            r.kind   = KIND_BAD_HEADER;
          end else begin
            if (r.msg_length != 0) begin
              in_body   = 1'b1;
              body_left = r.msg_length;
            end
            r.kind = KIND_HEADER;
            r.last = (r.msg_length == 0);
          end
          frame_events.push_back(r);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lim_type   = MAX_TYPE_RESET;
      lim_len    = MAX_LENGTH_RESET;
      fail_count = 0;
      clear_parse();
      frame_events.delete();
    end else begin
      if (pop && !empty) begin
        if (frame_events.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: kind %0d stamp %0h",
                                    result.kind, result.out_stamp));
        end else begin
          want = frame_events[0];
          frame_events.delete(0);
          check_field("kind", result.kind, want.kind);
          check_field("msg_type", result.msg_type, want.msg_type);
          check_field("msg_length", result.msg_length, want.msg_length);
          check_field("payload_byte", result.payload_byte, want.payload_byte);
          check_field("last", result.last, want.last);
          check_field("out_stamp", result.out_stamp, want.out_stamp);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_TYPE) begin
          lim_type = cfg_data;
        end else if (cfg_index == REG_MAX_LENGTH) begin
          lim_len = cfg_data;
        end
      end
      if (push && !full) parse_word(item);
    end
    outstanding = frame_events.size();
  end

endmodule

### tb/tb_length_prefixed_frame_parser_core.sv
`timescale 1ns / 1ps
// Top of the frame parser testbench: clock, reset, stimulus and verdict.
// Depends on lpfp_pkg, length_prefixed_frame_parser_core and lpfp_checker.
module tb_length_prefixed_frame_parser_core;
  import lpfp_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_WORDS  = 275;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  item_t                item      = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_TYPE;
  logic [31:0]          cfg_data  = '0;

  int          fail_count;
  int unsigned outstanding;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          words_sent    = 0;
  int          quiet_cycles  = 0;
  logic [31:0] lim_type      = MAX_TYPE_RESET;
  logic [31:0] lim_len       = MAX_LENGTH_RESET;

  length_prefixed_frame_parser_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lpfp_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] pick_stamp();
    case ($urandom_range(0, 9))
      0:       pick_stamp = 64'h8000_0000_0000_0000;
      1:       pick_stamp = 64'h7FFF_FFFF_FFFF_FFFF;
      2:       pick_stamp = '0;
      3:       pick_stamp = '1;
      default: pick_stamp = {$urandom, $urandom};
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with push still high, so back-to-back words keep it asserted.
  task automatic push_word(input item_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic put_word(input logic act, input logic [7:0] b);
    item_t w;
    w.action    = act;
    w.data_byte = b;
    w.stamp     = pick_stamp();
    push_word(w);
  endtask

  // Header words go out little-endian: type first, then length.
  task automatic put_header(input logic [31:0] t, input logic [31:0] l);
    for (int i = 0; i < 4; i++) put_word(ACT_BYTE, t[8*i +: 8]);
    for (int i = 0; i < 4; i++) put_word(ACT_BYTE, l[8*i +: 8]);
  endtask

  // Waits until every expected result is out and the pipeline is quiet.
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_limits(input logic [31:0] t, input logic [31:0] l);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? REG_MAX_TYPE : REG_MAX_LENGTH;
      cfg_data  <= (i == 0) ? t : l;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    lim_type = t;
    lim_len  = l;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 46; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 46; end
      default: begin send_idle_pct = 22; stall_pct = 22; end
    endcase
  endtask

  // One frame's worth of traffic: mostly good frames, plus bad headers,
  // truncated headers and raw noise, each of the latter ended by a close.
  task automatic run_frame();
    int          sel;
    int          n;
    int          cap;
    logic [31:0] t;
    logic [31:0] l;
    sel = $urandom_range(0, 99);
    cap = ($urandom_range(0, 9) == 0) ? 48 : 12;
    if (lim_len < cap) cap = lim_len;
    l = $urandom_range(0, cap);
    case ($urandom_range(0, 3))
      0:       t = '0;
      1:       t = lim_type;
      default: t = $urandom_range(0, lim_type);
    endcase
    if (sel < 65) begin
      put_header(t, l);
      if (l != 0 && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, l - 1);
        repeat (n) put_word(ACT_BYTE, 8'($urandom));
        put_word(ACT_CLOSE, 8'($urandom));
      end else begin
        repeat (l) put_word(ACT_BYTE, 8'($urandom));
        if ($urandom_range(0, 3) == 0) put_word(ACT_CLOSE, 8'($urandom));
      end
    end else if (sel < 77 && (lim_type != '1 || lim_len != '1)) begin
      if (lim_type != '1 && (lim_len == '1 || $urandom_range(0, 1) == 1)) begin
        t = ($urandom_range(0, 1) == 1) ? lim_type + 32'd1
                                         : $urandom_range(lim_type + 32'd1, 32'hFFFF_FFFF);
      end else begin
        l = ($urandom_range(0, 1) == 1) ? lim_len + 32'd1
                                         : $urandom_range(lim_len + 32'd1, 32'hFFFF_FFFF);
      end
      put_header(t, l);
      // Bytes after a cancel are dropped, so they do not count as traffic.
      n = $urandom_range(0, 4);
      repeat (n) put_word(ACT_BYTE, 8'($urandom));
      words_sent -= n;
      put_word(ACT_CLOSE, 8'($urandom));
    end else begin
      n = (sel < 89) ? $urandom_range(1, 7) : $urandom_range(1, 12);
      repeat (n) put_word(ACT_BYTE, 8'($urandom));
      put_word(ACT_CLOSE, 8'($urandom));
    end
  endtask

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        settle();
        case (p)
          1:       load_limits('0, '0);
          2:       load_limits('1, '1);
          3:       load_limits($urandom, $urandom);
          4:       load_limits($urandom_range(1, 300), $urandom_range(1, 30));
          default: load_limits(MAX_TYPE_RESET, MAX_LENGTH_RESET);
        endcase
      end
      set_idling(p % 4);
      if (p == 0) begin
        // Zero-length frame at the largest type.
        put_header(MAX_TYPE_RESET, '0);
        // Largest length, one payload word, then a close in mid-payload.
        put_header('0, MAX_LENGTH_RESET);
        put_word(ACT_BYTE, 8'hFF);
        put_word(ACT_CLOSE, 8'h00);
        // Close during a partial header, then a close between frames.
        put_word(ACT_BYTE, 8'h00);
        put_word(ACT_CLOSE, 8'hFF);
        put_word(ACT_CLOSE, 8'h00);
        // Bad header, a word that must be dropped, and a close after cancel.
        put_header('1, '1);
        put_word(ACT_BYTE, 8'hA5);
        put_word(ACT_CLOSE, 8'h5A);
      end
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) run_frame();
    end
    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
src/lpfp_pkg.sv
src/lpfp_front.sv
src/lpfp_queue.sv
src/lpfp_back.sv
src/length_prefixed_frame_parser_core.sv
src/lpfp_checker.sv
tb/lpfp_checker.sv
tb/tb_length_prefixed_frame_parser_core.sv
